FILE: hw/rtl/lpg_pkg.sv
// lpg_pkg: shared types, codes and constants for the line pixel generator.
// Used by lpg_ctrl, lpg_dpath and line_pixel_generator; depends on nothing.
`default_nettype none

package lpg_pkg;

    // Default geometry of the design
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int FRAME_BITS    = 12;
    localparam int CFG_DATA_BITS = FRAME_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_MODE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 12'd960;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 12'd720;

    // Line stepping methods
    localparam logic MODE_DDA  = 1'b0;
    localparam logic MODE_BRES = 1'b1;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic {
        ST_READY,
        ST_DIV
    } t_lpg_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch endpoints and set up the divider
        logic div_step;  // one quotient bit of the DDA increments
        logic tick;      // emit the current pixel and advance
    } t_lpg_cmd;

    // Datapath to controller
    typedef struct packed {
        logic line_active;
        logic div_done;
    } t_lpg_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/lpg_ctrl.sv
// lpg_ctrl: controller state machine of the line pixel generator.
// Owns the input ready, the output valid and the commands to lpg_dpath; uses lpg_pkg.
`default_nettype none

module lpg_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_kind,
    input  wire                i_out_ready,
    input  lpg_pkg::t_lpg_sts  i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output lpg_pkg::t_lpg_cmd  o_cmd
);
    import lpg_pkg::*;

    t_lpg_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_READY: begin
                // The output register must be free, or be emptied this cycle.
                o_in_ready = !r_out_valid || i_out_ready;
                w_accept   = i_in_valid && o_in_ready;
                o_cmd.load = w_accept && (i_kind == KIND_LOAD);
                o_cmd.tick = w_accept && (i_kind == KIND_TICK) && i_sts.line_active;
                if (o_cmd.load) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                w_accept       = 1'b0;
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_READY;
                end
            end
            default: begin
                w_accept = 1'b0;
                n_state  = ST_READY;
            end
        endcase

        if (o_cmd.tick) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/lpg_dpath.sv
// lpg_dpath: datapath of the line pixel generator: line state, both stepping
// methods, the serial increment divider and the output register. Uses lpg_pkg.
`default_nettype none

module lpg_dpath #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpg_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  lpg_pkg::t_lpg_cmd                    i_cmd,
    output lpg_pkg::t_lpg_sts                    o_sts,
    input  wire signed [COORD_BITS-1:0]          i_start_x,
    input  wire signed [COORD_BITS-1:0]          i_start_y,
    input  wire signed [COORD_BITS-1:0]          i_end_x,
    input  wire signed [COORD_BITS-1:0]          i_end_y,
    input  wire                                  i_line_mode,
    input  wire        [lpg_pkg::FRAME_BITS-1:0] i_frame_width,
    input  wire        [lpg_pkg::FRAME_BITS-1:0] i_frame_height,
    output logic signed [COORD_BITS-1:0]         o_pixel_x,
    output logic signed [COORD_BITS-1:0]         o_pixel_y,
    output logic                                 o_inside_res,
    output logic                                 o_last
);
    import lpg_pkg::*;

    localparam int ADW   = COORD_BITS + 1;              // magnitude of a delta
    localparam int ERW   = ADW + 2;                     // error term
    localparam int E2W   = ERW + 1;                     // doubled error term
    localparam int ACC_W = COORD_BITS + 2 + FRAC_BITS;  // DDA accumulator
    localparam int PXW   = ACC_W + 1 - FRAC_BITS;       // pixel before truncation
    localparam int QW    = FRAC_BITS + 1;               // increment magnitude
    localparam int RW    = ADW + 1;                     // divider remainder
    localparam int DCW   = $clog2(FRAC_BITS);

    function automatic logic signed [PXW-1:0] round_acc(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] m;
        logic [ACC_W:0]   s;
        logic [PXW-1:0]   r;
        m = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        s = {1'b0, m} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
        r = s[ACC_W:FRAC_BITS];
        return a[ACC_W-1] ? $signed(-r) : $signed(r);
    endfunction

    function automatic logic in_range(input logic signed [PXW-1:0] p,
                                      input logic [FRAME_BITS-1:0] lim);
        return !p[PXW-1] &&
               ({{(FRAME_BITS+1){1'b0}}, p} < {{(PXW+1){1'b0}}, lim});
    endfunction

    // Line state
    logic                         r_active;
    logic [ADW-1:0]               r_steps_left;
    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic [ADW-1:0]               r_adx;
    logic signed [ADW:0]          r_nady;
    logic signed [ERW-1:0]        r_err;
    logic                         r_dir_x_neg, r_dir_y_neg;
    logic signed [ACC_W-1:0]      r_acc_x, r_acc_y;
    logic                         r_neg_x, r_neg_y;
    // Divider
    logic [ADW-1:0]               r_steps;
    logic [RW-1:0]                r_rem_x, r_rem_y;
    logic [QW-1:0]                r_q_x, r_q_y;
    logic [DCW-1:0]               r_div_cnt;
    // Output register
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic                         r_inside, r_last;

    // Set-up of a new line
    logic signed [ADW-1:0] w_dx, w_dy;
    logic [ADW-1:0]        w_adx, w_ady, w_steps;
    logic                  w_qi_x, w_qi_y;

    assign w_dx    = $signed({i_end_x[COORD_BITS-1], i_end_x})
                   - $signed({i_start_x[COORD_BITS-1], i_start_x});
    assign w_dy    = $signed({i_end_y[COORD_BITS-1], i_end_y})
                   - $signed({i_start_y[COORD_BITS-1], i_start_y});
    assign w_adx   = w_dx[ADW-1] ? ADW'(-w_dx) : ADW'(w_dx);
    assign w_ady   = w_dy[ADW-1] ? ADW'(-w_dy) : ADW'(w_dy);
    assign w_steps = (w_adx > w_ady) ? w_adx : w_ady;
    // Integer part of |d| / steps is zero or one.
    assign w_qi_x  = w_adx >= w_steps;
    assign w_qi_y  = w_ady >= w_steps;

    // One restoring division step per axis
    logic [RW-1:0] w_rem2_x, w_rem2_y;
    logic          w_ge_x, w_ge_y;

    assign w_rem2_x = {r_rem_x[RW-2:0], 1'b0};
    assign w_rem2_y = {r_rem_y[RW-2:0], 1'b0};
    assign w_ge_x   = w_rem2_x >= {1'b0, r_steps};
    assign w_ge_y   = w_rem2_y >= {1'b0, r_steps};

    // Bresenham step
    logic signed [E2W-1:0] w_e2, w_nady_e, w_adx_e, w_err_n;
    logic                  w_xstep, w_ystep;

    assign w_e2     = {r_err, 1'b0};
    assign w_nady_e = {{(E2W-ADW-1){r_nady[ADW]}}, r_nady};
    assign w_adx_e  = $signed({{(E2W-ADW){1'b0}}, r_adx});
    assign w_xstep  = w_e2 >= w_nady_e;
    assign w_ystep  = w_e2 <= w_adx_e;
    assign w_err_n  = {r_err[ERW-1], r_err}
                    + (w_xstep ? w_nady_e : '0)
                    + (w_ystep ? w_adx_e : '0);

    // DDA increments, signed
    logic signed [ACC_W-1:0] w_inc_x, w_inc_y;

    assign w_inc_x = r_neg_x ? $signed(-{{(ACC_W-QW){1'b0}}, r_q_x})
                             : $signed({{(ACC_W-QW){1'b0}}, r_q_x});
    assign w_inc_y = r_neg_y ? $signed(-{{(ACC_W-QW){1'b0}}, r_q_y})
                             : $signed({{(ACC_W-QW){1'b0}}, r_q_y});

    // Pixel for the current tick
    logic signed [PXW-1:0] w_px, w_py;
    logic                  w_fin;

    always_comb begin
        if (i_line_mode == MODE_BRES) begin
            w_px = {{(PXW-COORD_BITS){r_cur_x[COORD_BITS-1]}}, r_cur_x};
            w_py = {{(PXW-COORD_BITS){r_cur_y[COORD_BITS-1]}}, r_cur_y};
        end else begin
            w_px = round_acc(r_acc_x);
            w_py = round_acc(r_acc_y);
        end
    end

    assign w_fin = (r_steps_left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_div_cnt <= '0;
        end else if (i_cmd.load) begin
            r_active  <= 1'b1;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DCW'(1);
        end else if (i_cmd.tick && w_fin) begin
            r_active  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x      <= i_start_x;
            r_cur_y      <= i_start_y;
            r_adx        <= w_adx;
            r_nady       <= -$signed({1'b0, w_ady});
            r_err        <= $signed({2'b00, w_adx}) - $signed({2'b00, w_ady});
            r_dir_x_neg  <= !(i_start_x < i_end_x);
            r_dir_y_neg  <= !(i_start_y < i_end_y);
            r_acc_x      <= {{2{i_start_x[COORD_BITS-1]}}, i_start_x, FRAC_BITS'(0)};
            r_acc_y      <= {{2{i_start_y[COORD_BITS-1]}}, i_start_y, FRAC_BITS'(0)};
            r_neg_x      <= w_dx[ADW-1];
            r_neg_y      <= w_dy[ADW-1];
            r_steps      <= w_steps;
            r_steps_left <= w_steps;
            r_rem_x      <= {1'b0, w_qi_x ? (w_adx - w_steps) : w_adx};
            r_rem_y      <= {1'b0, w_qi_y ? (w_ady - w_steps) : w_ady};
            r_q_x        <= QW'(w_qi_x);
            r_q_y        <= QW'(w_qi_y);
        end else if (i_cmd.div_step) begin
            r_rem_x <= w_ge_x ? (w_rem2_x - {1'b0, r_steps}) : w_rem2_x;
            r_rem_y <= w_ge_y ? (w_rem2_y - {1'b0, r_steps}) : w_rem2_y;
            r_q_x   <= {r_q_x[QW-2:0], w_ge_x};
            r_q_y   <= {r_q_y[QW-2:0], w_ge_y};
        end else if (i_cmd.tick && !w_fin) begin
            // Both methods advance on every tick but the final one of a line.
            r_err        <= ERW'(w_err_n);
            if (w_xstep) begin
                r_cur_x <= r_cur_x + (r_dir_x_neg ? '1 : COORD_BITS'(1));
            end
            if (w_ystep) begin
                r_cur_y <= r_cur_y + (r_dir_y_neg ? '1 : COORD_BITS'(1));
            end
            r_acc_x      <= r_acc_x + w_inc_x;
            r_acc_y      <= r_acc_y + w_inc_y;
            r_steps_left <= r_steps_left - ADW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_px     <= w_px[COORD_BITS-1:0];
            r_py     <= w_py[COORD_BITS-1:0];
            r_inside <= in_range(w_px, i_frame_width) && in_range(w_py, i_frame_height);
            r_last   <= w_fin;
        end
    end

    assign o_sts.line_active = r_active;
    assign o_sts.div_done    = (r_div_cnt == DCW'(FRAC_BITS - 1));
    assign o_pixel_x         = r_px;
    assign o_pixel_y         = r_py;
    assign o_inside_res      = r_inside;
    assign o_last            = r_last;

endmodule

`default_nettype wire

FILE: hw/rtl/line_pixel_generator.sv
// line_pixel_generator: top level of the line rasteriser (Bresenham and DDA).
// Holds the configuration registers; instantiates lpg_ctrl and lpg_dpath; uses lpg_pkg.
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ----------------------------------------
//  in        sink       i_in_valid / o_in_ready     i_kind, i_start_x/y, i_end_x/y
//  out       source     o_out_valid / i_out_ready   o_pixel_x/y, o_inside_res, o_last
//  cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A tick transaction's pixel appears in the output register on the next cycle, so a line
// streams at one pixel per cycle while the consumer keeps up. A load transaction sets up
// a radix-2 restoring divider that produces the DDA increments one quotient bit per cycle,
// and o_in_ready stays low while the divider runs.
// Reset clears the controller and leaves no line loaded; the registers return to DDA
// mode and a 960 by 720 frame. Ticks received with no line loaded produce nothing.
// A stalled consumer holds the output register; o_in_ready then falls until that
// transaction is taken. Configuration writes are always accepted.
`default_nettype none

module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpg_pkg::FRAC_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // Configuration write channel
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire        [lpg_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire        [lpg_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // Input channel
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  wire                                     i_kind,
    input  wire signed [COORD_BITS-1:0]             i_start_x,
    input  wire signed [COORD_BITS-1:0]             i_start_y,
    input  wire signed [COORD_BITS-1:0]             i_end_x,
    input  wire signed [COORD_BITS-1:0]             i_end_y,
    // Output channel
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic signed [COORD_BITS-1:0]            o_pixel_x,
    output logic signed [COORD_BITS-1:0]            o_pixel_y,
    output logic                                    o_inside_res,
    output logic                                    o_last
);
    import lpg_pkg::*;

    // Configuration registers. The user must write them only while the block is idle; the block
    // itself does not enforce this and takes every write without back-pressure.
    logic                  r_line_mode;
    logic [FRAME_BITS-1:0] r_frame_width;
    logic [FRAME_BITS-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode    <= MODE_DDA;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_MODE:    r_line_mode    <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_BITS-1:0];
                default: ;  // unknown index: the write is dropped
            endcase
        end
    end

    t_lpg_cmd s_cmd;
    t_lpg_sts s_sts;

    // The controller decides when a transaction is taken and what it does;
    // the datapath holds every piece of line state.
    lpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .i_sts       (s_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (s_cmd)
    );

    lpg_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_sts          (s_sts),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_line_mode    (r_line_mode),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_inside_res   (o_inside_res),
        .o_last         (o_last)
    );

    // A load starts the divider, so nothing is accepted on the following cycle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load |=> !o_in_ready)
        else $error("input accepted while the increment divider runs");

    // Once the final pixel of a line has been produced, the line is closed.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.tick |=> (!o_last || !s_sts.line_active))
        else $error("line still active after its final pixel");

    // Input is only taken when the output register can take a new pixel.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input ready while a pixel waits in the output register");

    // A pixel is only produced for a loaded line.
    a_tick_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.tick |-> s_sts.line_active)
        else $error("pixel produced with no line loaded");

endmodule

`default_nettype wire
